@@ rtl/mat4_vertex_transform_top_defines.svh @@
// Assertion macros shared by the mat4 vertex transform RTL.
// Depends on a clock aclk and an active-low reset aresetn in the using module.
`ifndef MAT4_VERTEX_TRANSFORM_TOP_DEFINES_SVH
`define MAT4_VERTEX_TRANSFORM_TOP_DEFINES_SVH

// same-cycle implication
`define M4VT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define M4VT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/m4vt_pkg.sv @@
// Types, constants and fixed-point helpers for the mat4 vertex transform.
// No dependencies.
`default_nettype none

package m4vt_pkg;

    localparam int FRAC_BITS = 16;

    typedef logic signed [31:0] fx_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [65:0] acc_t;

    typedef fx_t   fxmat_t   [16];
    typedef prod_t prodmat_t [16];
    typedef fx_t   vec_t     [4];

    typedef enum logic [2:0] {
        OP_WRITE     = 3'd0,
        OP_IDENTITY  = 3'd1,
        OP_TRANSLATE = 3'd2,
        OP_SCALE     = 3'd3,
        OP_COL_XFORM = 3'd4,
        OP_ROW_XFORM = 3'd5
    } op_t;

    typedef struct packed {
        logic       fire;
        op_t        op;
        logic [3:0] idx;
        fx_t        value;
    } mat_req_t;

    localparam fx_t  ONE_FX     = fx_t'(64'sd1 <<< FRAC_BITS);
    localparam fx_t  FX_MAX     = 32'sh7FFF_FFFF;
    localparam fx_t  FX_MIN     = 32'sh8000_0000;
    localparam acc_t ACC_MAX    = acc_t'(64'sh7FFF_FFFF);
    localparam acc_t ACC_MIN    = acc_t'(-64'sh8000_0000);
    localparam acc_t ROUND_HALF = acc_t'(64'sd1 <<< (FRAC_BITS - 1));

    function automatic fx_t identity_word(input logic [3:0] i);
        return (i[1:0] == i[3:2]) ? ONE_FX : '0;
    endfunction

    function automatic acc_t sum4(input prod_t a, input prod_t b, input prod_t c,
                                  input prod_t d);
        return acc_t'(a) + acc_t'(b) + acc_t'(c) + acc_t'(d);
    endfunction

    // round half up, drop fraction, saturate to 32 bits
    function automatic fx_t round_sat(input acc_t s);
        acc_t r;
        r = (s + ROUND_HALF) >>> FRAC_BITS;
        if (r > ACC_MAX) begin
            return FX_MAX;
        end else if (r < ACC_MIN) begin
            return FX_MIN;
        end
        return fx_t'(r);
    endfunction

endpackage

`default_nettype wire

@@ rtl/m4vt_mul_array.sv @@
// Sixteen 32x32 signed multipliers, one per matrix element.
// Depends on m4vt_pkg.
`default_nettype none

module m4vt_mul_array (
    input  m4vt_pkg::fxmat_t   mat,
    input  m4vt_pkg::vec_t     vec,
    input  logic               row_mode,
    output m4vt_pkg::prodmat_t prod
);
    import m4vt_pkg::*;

    for (genvar g = 0; g < 16; g++) begin : g_mul
        localparam int ROW = g / 4;
        localparam int COL = g % 4;
        fx_t rhs;
        // row mode weights by the vector entry of the row, else of the column
        assign rhs     = row_mode ? vec[ROW] : vec[COL];
        assign prod[g] = prod_t'(mat[g]) * prod_t'(rhs);
    end

endmodule

`default_nettype wire

@@ rtl/m4vt_matrix.sv @@
// Matrix store with element write, identity load and right composition.
// Depends on m4vt_pkg; products come from m4vt_mul_array.
`default_nettype none

module m4vt_matrix (
    input  logic               aclk,
    input  logic               aresetn,
    input  m4vt_pkg::mat_req_t req,
    input  m4vt_pkg::prodmat_t prod,
    output m4vt_pkg::fxmat_t   mat
);
    import m4vt_pkg::*;

    fxmat_t mat_reg;
    fxmat_t mat_next;

    always_comb begin
        mat_next = mat_reg;
        if (req.fire) begin
            case (req.op)
                OP_WRITE: begin
                    mat_next[req.idx] = req.value;
                end
                OP_IDENTITY: begin
                    for (int i = 0; i < 16; i++) begin
                        mat_next[i] = identity_word(4'(i));
                    end
                end
                OP_TRANSLATE: begin
                    for (int r = 0; r < 4; r++) begin
                        mat_next[r*4+3] = round_sat(sum4(prod[r*4], prod[r*4+1],
                            prod[r*4+2], prod_t'(mat_reg[r*4+3]) <<< FRAC_BITS));
                    end
                end
                OP_SCALE: begin
                    for (int r = 0; r < 4; r++) begin
                        for (int c = 0; c < 3; c++) begin
                            mat_next[r*4+c] = round_sat(acc_t'(prod[r*4+c]));
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= identity_word(4'(i));
            end
        end else begin
            mat_reg <= mat_next;
        end
    end

    assign mat = mat_reg;

endmodule

`default_nettype wire

@@ rtl/mat4_vertex_transform_top.sv @@
// Top level of the mat4 vertex transform: request register, multiplier
// array, matrix store and result register. Depends on m4vt_pkg,
// m4vt_mul_array, m4vt_matrix and the assertion macro header.
`default_nettype none
`include "mat4_vertex_transform_top_defines.svh"

// One request per cycle, unless stalled as below. An accepted request is held in
// the request register, where sixteen 32x32 multipliers feed four-term sums
// with round-half-up and saturation; transform results are then registered in
// the result register, which drives m_valid and the outputs. Matrix edits
// (write, identity, translate, scale) take effect for the very next request
// and give no result. The only stall is a held result with m_ready low while
// the next transform waits behind it. Matrix resets to identity.
module mat4_vertex_transform_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_operation,
    input  logic [3:0]          s_element_index,
    input  logic signed [31:0]  s_comp_a,
    input  logic signed [31:0]  s_comp_b,
    input  logic signed [31:0]  s_comp_c,
    input  logic signed [31:0]  s_comp_d,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_out_x,
    output logic signed [31:0]  m_out_y,
    output logic signed [31:0]  m_out_z,
    output logic signed [31:0]  m_out_w
);
    import m4vt_pkg::*;

    logic       in_valid_reg;
    op_t        op_reg;
    logic [3:0] idx_reg;
    vec_t       vec_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    vec_t       out_reg;
    vec_t       out_next;

    fxmat_t     mat;
    prodmat_t   prod;
    mat_req_t   req;
    logic       row_mode;
    logic       has_result;
    logic       fire;

    assign row_mode   = (op_reg == OP_ROW_XFORM);
    assign has_result = (op_reg == OP_COL_XFORM) || row_mode;
    assign fire       = in_valid_reg && (!has_result || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg     <= op_t'(s_operation);
            idx_reg    <= s_element_index;
            vec_reg[0] <= s_comp_a;
            vec_reg[1] <= s_comp_b;
            vec_reg[2] <= s_comp_c;
            vec_reg[3] <= s_comp_d;
        end
    end

    m4vt_mul_array u_mul (
        .mat      (mat),
        .vec      (vec_reg),
        .row_mode (row_mode),
        .prod     (prod)
    );

    always_comb begin
        req.fire  = fire;
        req.op    = op_reg;
        req.idx   = idx_reg;
        req.value = vec_reg[0];
    end

    m4vt_matrix u_matrix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .prod    (prod),
        .mat     (mat)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (row_mode) begin
                out_next[i] = round_sat(sum4(prod[i], prod[4+i], prod[8+i], prod[12+i]));
            end else begin
                out_next[i] = round_sat(sum4(prod[i*4], prod[i*4+1], prod[i*4+2],
                                             prod[i*4+3]));
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (fire && has_result) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && has_result) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_out_x = out_reg[0];
    assign m_out_y = out_reg[1];
    assign m_out_z = out_reg[2];
    assign m_out_w = out_reg[3];

    `M4VT_ASSERT_NEXT(a_accept_loads, s_valid && s_ready, in_valid_reg,
        "request not registered")
    `M4VT_ASSERT_NEXT(a_result_shows, fire && has_result, m_valid, "result lost")
    `M4VT_ASSERT_NOW(a_no_overwrite, m_valid && !m_ready, !(fire && has_result),
        "held result overwritten")
    `M4VT_ASSERT_NEXT(a_identity_load, fire && op_reg == OP_IDENTITY,
        mat[0] == ONE_FX && mat[1] == '0, "identity not loaded")
    `M4VT_ASSERT_NOW(a_edit_no_stall, in_valid_reg && !has_result, fire,
        "matrix edit stalled")

endmodule

`default_nettype wire
